@@ sv/npd_pkg.sv @@
// package for the npd tree cascade window classifier
// holds widths, command codes and the tdata layout; no dependencies
package npd_pkg;

    localparam int WinPixels  = 4096;
    localparam int MaxNodes   = 4096;
    localparam int MaxStages  = 1024;
    localparam int LeafDepth  = MaxNodes + MaxStages;

    localparam int PixAw   = $clog2(WinPixels);
    localparam int NodeAw  = $clog2(MaxNodes);
    localparam int StageAw = $clog2(MaxStages);
    localparam int LeafAw  = $clog2(LeafDepth);

    localparam int CmdBits  = 3;
    localparam int InBits   = 3 + 13 + 8 + 12 + 12 + 8 + 8 + 14 + 14 + 16 + 24 + 14;
    localparam int DataBits = InBits - CmdBits;
    localparam int InBytes  = (DataBits + 7) / 8;
    localparam int OutBits  = 1 + 24 + 11;
    localparam int OutBytes = (OutBits + 7) / 8;

    localparam logic signed [23:0] ScoreMax = 24'sh7fffff;
    localparam logic signed [23:0] ScoreMin = -24'sh800000;

    typedef enum logic [2:0] {
        CMD_LOAD_PIXEL = 3'd0,
        CMD_LOAD_NODE  = 3'd1,
        CMD_LOAD_STAGE = 3'd2,
        CMD_LOAD_LEAF  = 3'd3,
        CMD_EVAL       = 3'd4
    } cmd_t;

    typedef struct packed {
        logic signed [13:0] root_node;
        logic signed [23:0] threshold_value;
        logic signed [15:0] fit_value;
        logic signed [13:0] right_child;
        logic signed [13:0] left_child;
        logic [7:0]         cut_high;
        logic [7:0]         cut_low;
        logic [11:0]        pix_b;
        logic [11:0]        pix_a;
        logic [7:0]         pixel;
        logic [12:0]        index;
        logic [2:0]         cmd;
    } in_item_t;

    typedef struct packed {
        logic [10:0]        stages_passed;
        logic signed [23:0] score;
        logic               face;
    } out_item_t;

    // node record as stored in the node memory
    typedef struct packed {
        logic [11:0]        pix_a;
        logic [11:0]        pix_b;
        logic [7:0]         cut_low;
        logic [7:0]         cut_high;
        logic signed [13:0] left;
        logic signed [13:0] right;
    } node_t;

    typedef struct packed {
        logic signed [13:0] root;
        logic signed [23:0] thr;
    } stage_t;

endpackage

@@ sv/npd_feature.sv @@
// npd feature unit: floor(256*a/(a+b)) clamped to 255, 128 when a and b are both zero, one quotient bit a cycle
// depends on npd_pkg
module npd_feature (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic [7:0] pix_a,
    input  logic [7:0] pix_b,
    output logic       done,
    output logic [7:0] fea
);
    import npd_pkg::*;

    logic [8:0]  den_reg, den_next;
    logic [9:0]  rem_reg, rem_next;
    logic [8:0]  quo_reg, quo_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        zero_reg, zero_next;
    logic [9:0]  trial;

    assign trial = {rem_reg[8:0], 1'b0};

    always_comb begin
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        done      = 1'b0;
        if (start) begin
            // 256*a/(a+b): quotient <= 256, start with remainder a, 8 shift steps plus 1
            den_next  = {1'b0, pix_a} + {1'b0, pix_b};
            zero_next = (pix_a == 8'd0) && (pix_b == 8'd0);
            rem_next  = {2'b00, pix_a};
            quo_next  = 9'd0;
            cnt_next  = 4'd0;
            busy_next = 1'b1;
            // first bit: a >= a+b only when b == 0
            if ({1'b0, pix_a} >= ({1'b0, pix_a} + {1'b0, pix_b}) && !(pix_a == 8'd0 && pix_b == 8'd0)) begin
                quo_next = 9'd1;
                rem_next = 10'd0;
            end
        end else if (busy_reg) begin
            if (cnt_reg == 4'd8) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end else begin
                cnt_next = cnt_reg + 4'd1;
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = trial - {1'b0, den_reg};
                    quo_next = {quo_reg[7:0], 1'b1};
                end else begin
                    rem_next = trial;
                    quo_next = {quo_reg[7:0], 1'b0};
                end
            end
        end
    end

    assign fea = zero_reg ? 8'd128 : (quo_reg[8] ? 8'd255 : quo_reg[7:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        zero_reg <= zero_next;
    end
endmodule

@@ sv/npd_tree_cascade_window_classifier_unit.sv @@
// top level of the npd tree cascade window classifier
// depends on npd_pkg and npd_feature
//
// usage: s_axis transactions carry load commands (pixel, node, stage, leaf fit)
// and evaluate commands, the command in s_axis_tuser; loads produce no result,
// each evaluate produces one m_axis transaction {stages_passed, score, face}
// stores are synchronous memories with a registered read, undefined until
// written; num_stages is to be written through cfg_we / cfg_wdata only while
// idle, which the block does not enforce; loads leave the unit idle, so loads
// can stream back to back; an evaluate steps, after the accept, through a
// stage read per stage (ST_STAGE, ST_ROOT), per tree node the node read, pixel
// a, pixel b and the bit-serial feature divider (ST_NODE, ST_PIXA, ST_PIXB,
// ST_FEA), then the leaf fit (ST_LEAF) and the score update (ST_SUM); one more
// stage check follows when all stages pass, and the result then sits in the
// output register; the walk is bounded by MaxNodes visits per tree
// one item is in work at a time; s_axis_tready is low while an evaluate runs
// or while its result waits in the output register
// reset clears the control state and num_stages, not the memories
// a stalled m_axis_tready holds the result and blocks further input
module npd_tree_cascade_window_classifier_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // index, pixel, pix_a, pix_b, cut_low, cut_high, left_child,
    // right_child, fit_value, threshold_value, root_node, zero fill
    input  logic [npd_pkg::InBytes*8-1:0]  s_axis_tdata,
    // cmd
    input  logic [npd_pkg::CmdBits-1:0]    s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // face, score, stages_passed, zero fill
    output logic [npd_pkg::OutBytes*8-1:0] m_axis_tdata,
    input  logic                           cfg_we,
    input  logic [10:0]                    cfg_wdata
);
    import npd_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_STAGE  = 10'b0000000010,
        ST_ROOT   = 10'b0000000100,
        ST_NODE   = 10'b0000001000,
        ST_PIXA   = 10'b0000010000,
        ST_PIXB   = 10'b0000100000,
        ST_FEA    = 10'b0001000000,
        ST_LEAF   = 10'b0010000000,
        ST_SUM    = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    in_item_t in_item;
    assign in_item = in_item_t'({s_axis_tdata[DataBits-1:0], s_axis_tuser});

    logic [7:0]  pix_mem   [WinPixels];
    node_t       node_mem  [MaxNodes];
    stage_t      stage_mem [MaxStages];
    logic signed [15:0] leaf_mem [LeafDepth];

    logic [7:0]         pix_rd_reg;
    node_t              node_rd_reg;
    stage_t             stage_rd_reg;
    logic signed [15:0] leaf_rd_reg;

    logic [10:0] num_stages_reg;
    logic [10:0] count_reg, count_next;
    logic [10:0] stage_reg, stage_next;
    logic signed [23:0] score_reg, score_next;
    logic signed [23:0] thr_reg, thr_next;
    logic signed [13:0] cur_reg, cur_next;
    logic [12:0] visits_reg, visits_next;
    node_t       node_reg, node_next;
    logic [7:0]  pa_reg, pa_next;
    logic        face_reg, face_next;
    logic signed [15:0] fit_reg, fit_next;
    logic        fit_ok_reg, fit_ok_next;
    logic        mvalid_reg, mvalid_next;

    logic [PixAw-1:0]   pix_addr;
    logic [NodeAw-1:0]  node_addr;
    logic [StageAw-1:0] stage_addr;
    logic [LeafAw-1:0]  leaf_addr;
    logic               fea_start, fea_done;
    logic [7:0]         fea;
    logic               in_fire;
    logic [13:0]        leaf_idx;
    logic signed [24:0] sum;
    logic [7:0]         pix_val;

    assign s_axis_tready = state_reg == ST_IDLE;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign leaf_idx = 14'(-(cur_reg + 14'sd1));

    assign pix_val = pix_rd_reg;

    always_comb begin
        pix_addr = in_item.index[PixAw-1:0];
        unique case (state_reg)
            ST_NODE: pix_addr = node_rd_reg.pix_a[PixAw-1:0];
            ST_PIXA: pix_addr = node_reg.pix_b[PixAw-1:0];
            default: pix_addr = in_item.index[PixAw-1:0];
        endcase
    end
    // node read follows the next node so its record is ready in ST_NODE
    assign node_addr  = state_reg == ST_IDLE ? in_item.index[NodeAw-1:0]
                                             : cur_next[NodeAw-1:0];
    assign stage_addr = state_reg == ST_IDLE ? in_item.index[StageAw-1:0]
                                             : stage_reg[StageAw-1:0];
    assign leaf_addr  = state_reg == ST_IDLE ? in_item.index[LeafAw-1:0]
                                             : leaf_idx[LeafAw-1:0];

    always_ff @(posedge aclk) begin
        if (in_fire && in_item.cmd == CMD_LOAD_PIXEL && in_item.index < 13'(WinPixels))
            pix_mem[pix_addr] <= in_item.pixel;
        pix_rd_reg <= pix_mem[pix_addr];
    end

    always_ff @(posedge aclk) begin
        if (in_fire && in_item.cmd == CMD_LOAD_NODE && in_item.index < 13'(MaxNodes))
            node_mem[node_addr] <= '{in_item.pix_a, in_item.pix_b, in_item.cut_low,
                                    in_item.cut_high, in_item.left_child, in_item.right_child};
        node_rd_reg <= node_mem[node_addr];
    end

    always_ff @(posedge aclk) begin
        if (in_fire && in_item.cmd == CMD_LOAD_STAGE && in_item.index < 13'(MaxStages))
            stage_mem[stage_addr] <= '{in_item.root_node, in_item.threshold_value};
        stage_rd_reg <= stage_mem[stage_addr];
    end

    always_ff @(posedge aclk) begin
        if (in_fire && in_item.cmd == CMD_LOAD_LEAF && in_item.index < 13'(LeafDepth))
            leaf_mem[leaf_addr] <= in_item.fit_value;
        leaf_rd_reg <= leaf_mem[leaf_addr];
    end

    npd_feature u_fea (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fea_start),
        .pix_a   (pa_reg),
        .pix_b   (pix_val),
        .done    (fea_done),
        .fea     (fea)
    );

    assign sum = 25'(score_reg) + 25'(fit_reg);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        stage_next  = stage_reg;
        score_next  = score_reg;
        thr_next    = thr_reg;
        cur_next    = cur_reg;
        visits_next = visits_reg;
        node_next   = node_reg;
        pa_next     = pa_reg;
        face_next   = face_reg;
        fit_next    = fit_reg;
        fit_ok_next = fit_ok_reg;
        mvalid_next = mvalid_reg;
        fea_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && in_item.cmd == CMD_EVAL) begin
                    count_next = num_stages_reg > 11'(MaxStages) ? 11'(MaxStages)
                                                                  : num_stages_reg;
                    stage_next = '0;
                    score_next = '0;
                    face_next  = 1'b1;
                    state_next = ST_STAGE;
                end
            end
            ST_STAGE: begin
                if (stage_reg == count_reg) begin
                    mvalid_next = 1'b1;
                    state_next  = ST_OUT;
                end else begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                thr_next    = stage_rd_reg.thr;
                cur_next    = stage_rd_reg.root;
                visits_next = '0;
                state_next  = stage_rd_reg.root < 0 ? ST_LEAF : ST_NODE;
                if (stage_rd_reg.root >= 0
                    && stage_rd_reg.root >= signed'(14'(MaxNodes))) begin
                    fit_next    = '0;
                    fit_ok_next = 1'b1;
                    state_next  = ST_SUM;
                end
                if (stage_rd_reg.root < 0) fit_ok_next = 1'b0;
            end
            ST_NODE: begin
                node_next  = node_rd_reg;
                state_next = ST_PIXA;
            end
            ST_PIXA: begin
                pa_next    = pix_val;
                state_next = ST_PIXB;
            end
            ST_PIXB: begin
                fea_start  = 1'b1;
                state_next = ST_FEA;
            end
            ST_FEA: begin
                if (fea_done) begin
                    visits_next = visits_reg + 13'd1;
                    if (fea < node_reg.cut_low || fea > node_reg.cut_high)
                        cur_next = node_reg.left;
                    else
                        cur_next = node_reg.right;
                    priority if (cur_next < 0) begin
                        fit_ok_next = 1'b0;
                        state_next  = ST_LEAF;
                    end else if (cur_next >= signed'(14'(MaxNodes))
                                 || visits_next >= 13'(MaxNodes)) begin
                        fit_next    = '0;
                        fit_ok_next = 1'b1;
                        state_next  = ST_SUM;
                    end else begin
                        state_next = ST_NODE;
                    end
                end
            end
            ST_LEAF: begin
                // leaf read address settles in this cycle, data next
                if (fit_ok_reg) begin
                    fit_next   = leaf_idx < 14'(LeafDepth) ? leaf_rd_reg : 16'sd0;
                    state_next = ST_SUM;
                end else begin
                    fit_ok_next = 1'b1;
                end
            end
            ST_SUM: begin
                fit_ok_next = 1'b0;
                priority if (sum > 25'(ScoreMax)) score_next = ScoreMax;
                else if (sum < 25'(ScoreMin)) score_next = ScoreMin;
                else score_next = 24'(sum);
                if (score_next < thr_reg) begin
                    face_next   = 1'b0;
                    mvalid_next = 1'b1;
                    state_next  = ST_OUT;
                end else begin
                    stage_next = stage_reg + 11'd1;
                    state_next = ST_STAGE;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    mvalid_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mvalid_reg     <= 1'b0;
            num_stages_reg <= '0;
            fit_ok_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            fit_ok_reg <= fit_ok_next;
            if (cfg_we) num_stages_reg <= cfg_wdata;
        end
        count_reg  <= count_next;
        stage_reg  <= stage_next;
        score_reg  <= score_next;
        thr_reg    <= thr_next;
        cur_reg    <= cur_next;
        visits_reg <= visits_next;
        node_reg   <= node_next;
        pa_reg     <= pa_next;
        face_reg   <= face_next;
        fit_reg    <= fit_next;
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {{(OutBytes*8-OutBits){1'b0}},
                            out_item_t'({stage_reg, score_reg, face_reg})};
endmodule

@@ sv/npd_checker.sv @@
// port-level checker for the classifier top level, bound in below
// depends on npd_pkg
module npd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [npd_pkg::OutBytes*8-1:0] m_axis_tdata
);
    import npd_pkg::*;

    a_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("input open with result pending");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");

    a_face_zero_score: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[35:25] == 11'd0
        |-> m_axis_tdata[24:1] == 24'd0) else $error("accept with no stages has score");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid) else $error("result after reset");
endmodule

bind npd_tree_cascade_window_classifier_unit npd_checker u_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
